// ===== sv/grgdm_pkg.sv =====
// Shared types and constants for the gain ramp / growing delay mixer.
// No dependencies; the design files refer to it by scoped names, the testbench files import it.
package grgdm_pkg;

  localparam int unsigned DELAY_DEPTH_DEF    = 65536;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 40;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned MAX_GAIN_W   = 16;
  localparam int unsigned MAX_GAIN_FRAC = 12;
  localparam int unsigned GAIN_STEP_W  = 40;
  localparam int unsigned MAX_DELAY_W  = 16;
  localparam int unsigned DELAY_FRAC_W = 24;
  localparam int unsigned DELAY_ACC_W  = MAX_DELAY_W + DELAY_FRAC_W;

  localparam int unsigned APB_AW = 6;
  localparam int unsigned APB_DW = 64;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [MAX_GAIN_W-1:0] MAX_GAIN_RST = 16'd4915;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_COUNT,
    REG_MAX_GAIN,
    REG_GAIN_STEP,
    REG_MAX_DELAY,
    REG_DELAY_STEP
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_PASS,
    PH_RAMP,
    PH_MIX
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_RAMP_START,
    EV_MAX_GAIN,
    EV_FULL_DELAY
  } event_e;

  typedef struct packed {
    phase_e phase;
    event_e ev;
  } tag_t;

endpackage

// ===== sv/grgdm_in_if.sv =====
// Input word channel: one I or Q sample per word, valid/ready handshake.
// Depends on grgdm_pkg.
interface grgdm_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [grgdm_pkg::SAMPLE_W-1:0]      in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink (input valid, input in_sample, output ready);
endinterface

// ===== sv/grgdm_out_if.sv =====
// Result word channel: processed sample with phase and event code.
// Depends on grgdm_pkg.
interface grgdm_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [grgdm_pkg::SAMPLE_W-1:0]      out_sample;
  logic [1:0]                                 phase;
  logic [1:0]                                 event_res;

  modport source (output valid, output out_sample, output phase, output event_res,
                  input ready);
  modport sink (input valid, input out_sample, input phase, input event_res,
                output ready);
endinterface

// ===== sv/gain_ramp_growing_delay_mixer.sv =====
// Top level of the gain ramp / growing delay mixer with its APB register port.
// Depends on grgdm_pkg, grgdm_in_if, grgdm_out_if and grgdm_mix.
//
// Takes one sample word per clock while the output is not stalled and returns
// one result word per sample via the issue register and the mix pipeline. Count, gain, delay,
// ring head and fill are updated in registers in the accept cycle; the delay
// ring is a DELAY_DEPTH x 16 memory with one write and one registered read per
// cycle, the push and the read of the oldest entry issued together. A read of
// the entry being written (single held sample) is forwarded from the input. The
// ring needs no clearing after reset: only written entries are ever read. The
// multiply path is split into half-width partial products over two stages.
module gain_ramp_growing_delay_mixer #(
  parameter int unsigned DELAY_DEPTH    = grgdm_pkg::DELAY_DEPTH_DEF,
  parameter int unsigned GAIN_FRAC_BITS = grgdm_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [grgdm_pkg::APB_AW-1:0]   paddr,
  input  logic [grgdm_pkg::APB_DW-1:0]   pwdata,
  output logic [grgdm_pkg::APB_DW-1:0]   prdata,
  output logic                           pready,
  grgdm_in_if.sink                       in_i,
  grgdm_out_if.source                    out_o
);

  localparam int unsigned SW   = grgdm_pkg::SAMPLE_W;
  localparam int unsigned CNTW = grgdm_pkg::COUNT_W;
  localparam int unsigned DW   = grgdm_pkg::DELAY_ACC_W;
  localparam int unsigned DFW  = grgdm_pkg::DELAY_FRAC_W;
  localparam int unsigned AW   = $clog2(DELAY_DEPTH);
  localparam int unsigned FW   = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned OW   = FW + 1;
  localparam int unsigned GW   = GAIN_FRAC_BITS + 4;
  localparam int unsigned SUMW = ((GW > grgdm_pkg::GAIN_STEP_W) ? GW : grgdm_pkg::GAIN_STEP_W) + 1;
  localparam int unsigned CW   = (FW > grgdm_pkg::MAX_DELAY_W) ? FW : grgdm_pkg::MAX_DELAY_W;
  localparam int unsigned IDXL = $clog2(grgdm_pkg::APB_DW / 8);

  // configuration
  logic [CNTW-1:0]                       start_count_q;
  logic [grgdm_pkg::MAX_GAIN_W-1:0]      max_gain_q;
  logic [grgdm_pkg::GAIN_STEP_W-1:0]     gain_step_q;
  logic [grgdm_pkg::MAX_DELAY_W-1:0]     max_delay_q;
  logic [DFW-1:0]                        delay_step_q;
  logic                                  cfg_wr;
  logic [grgdm_pkg::REG_IDX_W-1:0]       cfg_idx;

  // stream state
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [GW-1:0]   gain_q, gain_d;
  logic [DW-1:0]   dacc_q, dacc_d;
  logic [AW-1:0]   head_q, head_d;
  logic [FW-1:0]   fill_q, fill_d;

  logic            in_rdy;
  logic            accept;
  logic [GW-1:0]   target;
  logic            is_mix, is_ramp, is_start;
  logic [SUMW-1:0] gsum;
  logic [DW-1:0]   dmax;
  logic [DW-1:0]   dsum;
  logic [FW-1:0]   fill_p;
  logic [OW-1:0]   hx, fx, oldx;
  logic [AW-1:0]   oldest;
  logic            fwd;
  logic [GW-1:0]   g_sel;
  grgdm_pkg::tag_t tag_d;

  // ring memory
  logic [SW-1:0]        ring_mem [DELAY_DEPTH];
  logic signed [SW-1:0] rdata_q;

  // read/issue stage
  logic                 s1_v_q;
  logic signed [SW-1:0] s1_s_q;
  logic [GW-1:0]        s1_g_q;
  grgdm_pkg::tag_t      s1_tag_q;
  logic                 s1_fwd_q;
  logic signed [SW-1:0] fac;
  logic                 mix_rdy;

  // APB
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[grgdm_pkg::APB_AW-1:IDXL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_count_q <= '0;
      max_gain_q    <= grgdm_pkg::MAX_GAIN_RST;
      gain_step_q   <= '0;
      max_delay_q   <= '0;
      delay_step_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        grgdm_pkg::REG_START_COUNT: start_count_q <= pwdata[CNTW-1:0];
        grgdm_pkg::REG_MAX_GAIN:    max_gain_q    <= pwdata[grgdm_pkg::MAX_GAIN_W-1:0];
        grgdm_pkg::REG_GAIN_STEP:   gain_step_q   <= pwdata[grgdm_pkg::GAIN_STEP_W-1:0];
        grgdm_pkg::REG_MAX_DELAY:   max_delay_q   <= pwdata[grgdm_pkg::MAX_DELAY_W-1:0];
        grgdm_pkg::REG_DELAY_STEP:  delay_step_q  <= pwdata[DFW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      grgdm_pkg::REG_START_COUNT: prdata = grgdm_pkg::APB_DW'(start_count_q);
      grgdm_pkg::REG_MAX_GAIN:    prdata = grgdm_pkg::APB_DW'(max_gain_q);
      grgdm_pkg::REG_GAIN_STEP:   prdata = grgdm_pkg::APB_DW'(gain_step_q);
      grgdm_pkg::REG_MAX_DELAY:   prdata = grgdm_pkg::APB_DW'(max_delay_q);
      grgdm_pkg::REG_DELAY_STEP:  prdata = grgdm_pkg::APB_DW'(delay_step_q);
      default:                    prdata = '0;
    endcase
  end

  // per-word control
  assign in_rdy    = !s1_v_q || mix_rdy;
  assign in_i.ready = in_rdy;
  assign accept    = in_i.valid && in_rdy;

  assign cnt_d    = (cnt_q == {CNTW{1'b1}}) ? cnt_q : cnt_q + CNTW'(1);
  assign target   = {max_gain_q, {(GAIN_FRAC_BITS - grgdm_pkg::MAX_GAIN_FRAC){1'b0}}};
  assign is_mix   = (gain_q == target);
  assign is_ramp  = !is_mix && (cnt_d > start_count_q);
  assign is_start = !is_mix && !is_ramp && (cnt_d == start_count_q);
  assign gsum     = SUMW'(gain_q) + SUMW'(gain_step_q);
  assign dmax     = {max_delay_q, {DFW{1'b0}}};
  assign dsum     = dacc_q + DW'(delay_step_q);

  always_comb begin
    gain_d    = gain_q;
    dacc_d    = dacc_q;
    head_d    = head_q;
    fill_p    = fill_q;
    g_sel     = '0;
    tag_d.phase = grgdm_pkg::PH_PASS;
    tag_d.ev    = grgdm_pkg::EV_NONE;
    if (is_mix) begin
      tag_d.phase = grgdm_pkg::PH_MIX;
      g_sel  = gain_q;
      head_d = (head_q == AW'(DELAY_DEPTH - 1)) ? '0 : head_q + AW'(1);
      fill_p = (fill_q < FW'(DELAY_DEPTH)) ? fill_q + FW'(1) : fill_q;
      if (dacc_q < dmax) begin
        dacc_d = dsum;
        if (dsum >= dmax) begin
          tag_d.ev = grgdm_pkg::EV_FULL_DELAY;
        end
      end else if (dacc_q > dmax) begin
        dacc_d = dmax;
      end
    end else if (is_ramp) begin
      tag_d.phase = grgdm_pkg::PH_RAMP;
      g_sel = gain_q;
      if (gsum >= SUMW'(target)) begin
        gain_d   = target;
        tag_d.ev = grgdm_pkg::EV_MAX_GAIN;
      end else begin
        gain_d = gsum[GW-1:0];
      end
    end else if (is_start) begin
      tag_d.ev = grgdm_pkg::EV_RAMP_START;
    end
    // drop the oldest entry while the ring holds more than the whole delay
    fill_d = (CW'(fill_p) > CW'(dacc_d[DW-1:DFW])) ? fill_p - FW'(1) : fill_p;
    hx     = OW'(head_d);
    fx     = OW'(fill_p);
    oldx   = (hx >= fx) ? (hx - fx) : (hx + OW'(DELAY_DEPTH) - fx);
    oldest = oldx[AW-1:0];
    fwd    = (fill_p == FW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      gain_q <= '0;
      dacc_q <= '0;
      head_q <= '0;
      fill_q <= '0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      gain_q <= gain_d;
      dacc_q <= dacc_d;
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // push and oldest read in the same cycle; read returns pre-write data
  always_ff @(posedge clk_i) begin
    if (accept && is_mix) begin
      ring_mem[head_q] <= in_i.in_sample;
      rdata_q          <= ring_mem[oldest];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_rdy) begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_s_q   <= in_i.in_sample;
      s1_g_q   <= g_sel;
      s1_tag_q <= tag_d;
      s1_fwd_q <= fwd;
    end
  end

  assign fac = ((s1_tag_q.phase == grgdm_pkg::PH_MIX) && !s1_fwd_q) ? rdata_q : s1_s_q;

  grgdm_mix #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_v_q),
    .ready_o (mix_rdy),
    .sample_i(s1_s_q),
    .fac_i   (fac),
    .gain_i  (s1_g_q),
    .tag_i   (s1_tag_q),
    .out_o   (out_o)
  );

endmodule

// ===== sv/grgdm_mix.sv =====
// Three-stage fixed-point mix: trunc(s + g * f) saturated to 16 bits.
// Split multiply, product sum, truncate/saturate into the output register.
// Depends on grgdm_pkg and grgdm_out_if.
module grgdm_mix #(
  parameter int unsigned GAIN_FRAC_BITS = grgdm_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [grgdm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic signed [grgdm_pkg::SAMPLE_W-1:0] fac_i,
  input  logic [GAIN_FRAC_BITS+3:0]             gain_i,
  input  grgdm_pkg::tag_t                       tag_i,
  grgdm_out_if.source                           out_o
);

  localparam int unsigned SW   = grgdm_pkg::SAMPLE_W;
  localparam int unsigned GW   = GAIN_FRAC_BITS + 4;
  localparam int unsigned GL   = GW / 2;
  localparam int unsigned GH   = GW - GL;
  localparam int unsigned PW   = SW + GW;
  localparam int unsigned WW   = PW - GAIN_FRAC_BITS;
  localparam int unsigned SUMW = WW + 2;

  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(32767);
  localparam logic signed [SUMW-1:0] SAT_LO = -SUMW'(32768);

  logic adv1, adv2, adv3;
  logic v1_q, v2_q, v3_q;

  // stage 1: magnitude and partial products
  logic                 neg;
  logic [SW-1:0]        mag;
  logic [SW+GL-1:0]     plo_d;
  logic [SW+GH-1:0]     phi_d;
  logic signed [SW-1:0] s1_q;
  logic                 neg1_q;
  grgdm_pkg::tag_t      tag1_q;
  logic [SW+GL-1:0]     plo_q;
  logic [SW+GH-1:0]     phi_q;

  // stage 2: full product
  logic [PW-1:0]        prod_d;
  logic signed [SW-1:0] s2_q;
  logic                 neg2_q;
  grgdm_pkg::tag_t      tag2_q;
  logic [PW-1:0]        prod_q;

  // stage 3: truncate toward zero, saturate
  logic [WW-1:0]          whole;
  logic                   frac;
  logic signed [SUMW-1:0] sx;
  logic signed [SUMW-1:0] wx;
  logic signed [SUMW-1:0] acc;
  logic signed [SW-1:0]   y_d;
  logic signed [SW-1:0]   y_q;
  grgdm_pkg::tag_t        tag3_q;

  assign adv3    = !v3_q || out_o.ready;
  assign adv2    = !v2_q || adv3;
  assign adv1    = !v1_q || adv2;
  assign ready_o = adv1;

  always_comb begin
    neg   = fac_i[SW-1];
    mag   = neg ? (SW'(~fac_i) + SW'(1)) : SW'(fac_i);
    plo_d = (SW+GL)'(mag) * (SW+GL)'(gain_i[GL-1:0]);
    phi_d = (SW+GH)'(mag) * (SW+GH)'(gain_i[GW-1:GL]);
  end

  assign prod_d = {phi_q, {GL{1'b0}}} + PW'(plo_q);

  always_comb begin
    whole = prod_q[PW-1:GAIN_FRAC_BITS];
    frac  = |prod_q[GAIN_FRAC_BITS-1:0];
    sx    = SUMW'(s2_q);
    wx    = signed'(SUMW'(whole));
    acc   = neg2_q ? (sx - wx) : (sx + wx);
    if (frac) begin
      if (!neg2_q && (acc < 0)) begin
        acc = acc + SUMW'(1);
      end else if (neg2_q && (acc > 0)) begin
        acc = acc - SUMW'(1);
      end
    end
    if (acc > SAT_HI) begin
      y_d = SW'(SAT_HI);
    end else if (acc < SAT_LO) begin
      y_d = SW'(SAT_LO);
    end else begin
      y_d = SW'(acc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      s1_q   <= sample_i;
      neg1_q <= neg;
      tag1_q <= tag_i;
      plo_q  <= plo_d;
      phi_q  <= phi_d;
    end
    if (adv2 && v1_q) begin
      s2_q   <= s1_q;
      neg2_q <= neg1_q;
      tag2_q <= tag1_q;
      prod_q <= prod_d;
    end
    if (adv3 && v2_q) begin
      y_q    <= y_d;
      tag3_q <= tag2_q;
    end
  end

  assign out_o.valid      = v3_q;
  assign out_o.out_sample = y_q;
  assign out_o.phase      = tag3_q.phase;
  assign out_o.event_res  = tag3_q.ev;

endmodule

// ===== tb/grgdm_mix_check.sv =====
`timescale 1ns / 100ps
// Result checker for the gain ramp / growing delay mixer: follows register writes,
// predicts every output word from the accepted samples and compares field by field.
// Depends on grgdm_pkg, grgdm_in_if and grgdm_out_if.
module grgdm_mix_check
  import grgdm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  grgdm_in_if               in_ch,
  grgdm_out_if              out_ch,
  output int                fail_cnt_o,
  output int                pending_o,
  output int                checked_o,
  output logic [3:0]        phases_seen_o,
  output logic [3:0]        events_seen_o
);

  localparam int unsigned DEPTH = DELAY_DEPTH_DEF;
  localparam int unsigned GFRAC = GAIN_FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    phase_e                     phase;
    event_e                     ev;
  } mix_word_t;

  logic [COUNT_W-1:0]     start_cnt;
  logic [MAX_GAIN_W-1:0]  max_gain;
  logic [GAIN_STEP_W-1:0] gain_step;
  logic [MAX_DELAY_W-1:0] max_delay;
  logic [DELAY_FRAC_W-1:0] delay_step;

  logic [COUNT_W-1:0]         item_cnt;
  logic [63:0]                gain_acc;
  logic [63:0]                delay_acc;
  logic signed [SAMPLE_W-1:0] delay_ring [DEPTH];
  int                         ring_head;
  int                         ring_fill;

  mix_word_t expected_words[$];
  int        fail_cnt;
  int        checked;

  // s + g * f, truncated toward zero as a whole, then saturated
  function automatic logic signed [SAMPLE_W-1:0] mix_trunc_sat(input int s, input int f,
                                                               input logic [63:0] g);
    logic [63:0] fmask, m, lo, whole;
    longint      acc;
    bit          frac;
    fmask = (64'd1 << GFRAC) - 64'd1;
    m = (f < 0) ? 64'(-f) : 64'(f);
    lo = m * (g & fmask);
    whole = m * (g >> GFRAC) + (lo >> GFRAC);
    frac = (lo & fmask) != 64'd0;
    acc = (f < 0) ? longint'(s) - longint'(whole) : longint'(s) + longint'(whole);
    if (frac) begin
      if (f >= 0 && acc < 0) acc++;
      else if (f < 0 && acc > 0) acc--;
    end
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[SAMPLE_W-1:0];
  endfunction

  task automatic predict_word(input logic signed [SAMPLE_W-1:0] s, output mix_word_t w);
    logic [63:0] target, dmax;
    int          oldest;
    w.sample = s;
    w.phase = PH_PASS;
    w.ev = EV_NONE;
    target = {48'd0, max_gain} << (GFRAC - MAX_GAIN_FRAC);
    dmax = {48'd0, max_delay} << DELAY_FRAC_W;
    if (item_cnt != '1) item_cnt++;
    if (gain_acc == target) begin
      w.phase = PH_MIX;
      delay_ring[ring_head] = s;
      ring_head = (ring_head + 1 == DEPTH) ? 0 : ring_head + 1;
      if (ring_fill < DEPTH) ring_fill++;
      oldest = (ring_head >= ring_fill) ? ring_head - ring_fill
                                        : ring_head + DEPTH - ring_fill;
      w.sample = mix_trunc_sat(s, delay_ring[oldest], gain_acc);
      if (delay_acc < dmax) begin
        delay_acc += {40'd0, delay_step};
        if (delay_acc >= dmax) w.ev = EV_FULL_DELAY;
      end else if (delay_acc > dmax) begin
        delay_acc = dmax;
      end
    end else if (item_cnt > start_cnt) begin
      w.phase = PH_RAMP;
      w.sample = mix_trunc_sat(s, s, gain_acc);
      gain_acc += {24'd0, gain_step};
      if (gain_acc >= target) begin
        gain_acc = target;
        w.ev = EV_MAX_GAIN;
      end
    end else if (item_cnt == start_cnt) begin
      w.ev = EV_RAMP_START;
    end
    if ((64'(ring_fill) << DELAY_FRAC_W) > delay_acc) ring_fill--;
  endtask

  task automatic report_mismatch(input string msg);
    fail_cnt++;
    $display("%0t ns: result word %0d: %s", $time, checked, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    mix_word_t want, pred;
    if (!rst_ni) begin
      start_cnt  <= '0;
      max_gain   <= MAX_GAIN_RST;
      gain_step  <= '0;
      max_delay  <= '0;
      delay_step <= '0;
      item_cnt = '0;
      gain_acc = '0;
      delay_acc = '0;
      ring_head = 0;
      ring_fill = 0;
      expected_words.delete();
      fail_cnt = 0;
      checked = 0;
      fail_cnt_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
      phases_seen_o <= '0;
      events_seen_o <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word, sample %0d phase %0d event %0d",
                                    out_ch.out_sample, out_ch.phase, out_ch.event_res));
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (out_ch.out_sample !== want.sample)
            report_mismatch($sformatf("out_sample %0d, expected %0d",
                                      out_ch.out_sample, want.sample));
          if (out_ch.phase !== want.phase)
            report_mismatch($sformatf("phase %0d, expected %0d", out_ch.phase, want.phase));
          if (out_ch.event_res !== want.ev)
            report_mismatch($sformatf("event_res %0d, expected %0d",
                                      out_ch.event_res, want.ev));
        end
        checked++;
        phases_seen_o[out_ch.phase] <= 1'b1;
        events_seen_o[out_ch.event_res] <= 1'b1;
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[APB_AW-1:3]))
          REG_START_COUNT: start_cnt  <= pwdata[COUNT_W-1:0];
          REG_MAX_GAIN:    max_gain   <= pwdata[MAX_GAIN_W-1:0];
          REG_GAIN_STEP:   gain_step  <= pwdata[GAIN_STEP_W-1:0];
          REG_MAX_DELAY:   max_delay  <= pwdata[MAX_DELAY_W-1:0];
          REG_DELAY_STEP:  delay_step <= pwdata[DELAY_FRAC_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_word(in_ch.in_sample, pred);
        expected_words.insert(expected_words.size(), pred);
      end
      fail_cnt_o <= fail_cnt;
      pending_o <= expected_words.size();
      checked_o <= checked;
    end
  end

endmodule

// ===== tb/gain_ramp_growing_delay_mixer_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the gain ramp / growing delay mixer: clock, reset, register
// writes and sample stimulus with random stalls; grgdm_mix_check does the checking.
// Depends on grgdm_pkg, grgdm_in_if, grgdm_out_if, gain_ramp_growing_delay_mixer and grgdm_mix_check.
module gain_ramp_growing_delay_mixer_tb;
  import grgdm_pkg::*;

  localparam int          ITEMS       = 550;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          LONG_HOLD   = 300;
  localparam logic [63:0] STEP_MAX    = (64'd1 << GAIN_STEP_W) - 64'd1;
  localparam logic [REG_IDX_W-1:0] SPARE_REG_IDX = 3'd6;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  grgdm_in_if  in_ch ();
  grgdm_out_if out_ch ();

  int         fail_cnt;
  int         pending;
  int         checked;
  logic [3:0] phases_seen;
  logic [3:0] events_seen;

  int samples_sent;
  int cfg_writes;
  bit idle_en;
  bit hold_req;

  gain_ramp_growing_delay_mixer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  grgdm_mix_check u_mix_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .checked_o     (checked),
    .phases_seen_o (phases_seen),
    .events_seen_o (events_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_ready
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) begin
          @(posedge clk_i);
          if (hold_req) break;
        end
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 15)) begin
          @(posedge clk_i);
          if (hold_req) break;
        end
      end
    end
  end

  task automatic reg_write(input reg_idx_e idx, input logic [63:0] val);
    logic [63:0] keep;
    case (idx)
      REG_START_COUNT: keep = 64'hFFFF_FFFF;
      REG_GAIN_STEP:   keep = STEP_MAX;
      REG_DELAY_STEP:  keep = 64'hFF_FFFF;
      default:         keep = 64'hFFFF;
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= (val & keep) | ({$urandom, $urandom} & ~keep);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_writes++;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_sample <= v;
    do @(posedge clk_i); while (!in_ch.ready);
    samples_sent++;
  endtask

  // stop sending and wait until every expected word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] sample;
    logic [MAX_GAIN_W-1:0]      mg;
    logic [63:0]                step;
    int                         n;
    int                         phase_cnt;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.in_sample <= '0;
    samples_sent = 0;
    cfg_writes = 0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero gain equals zero target: mixing from the first word, full delay reached
    reg_write(REG_MAX_GAIN, 64'd0);
    reg_write(REG_MAX_DELAY, 64'd3);
    reg_write(REG_DELAY_STEP, 64'hFF_FFFF);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample('1);
    send_sample('0);
    drain();

    // largest gain with largest step; zero max delay clamps the delay later
    reg_write(REG_START_COUNT, 64'(samples_sent + 2));
    reg_write(REG_MAX_GAIN, 64'hFFFF);
    reg_write(REG_GAIN_STEP, STEP_MAX);
    reg_write(REG_MAX_DELAY, 64'd0);
    for (int i = 0; i < 18; i++) begin
      case (i % 3)
        0:       send_sample(16'sh7FFF);
        1:       send_sample(-16'sh8000);
        default: send_sample(16'($urandom));
      endcase
    end
    drain();

    // gain above a lowered target clamps on the next ramp word; spare index ignored
    reg_write(REG_MAX_GAIN, 64'd100);
    reg_write(reg_idx_e'(SPARE_REG_IDX), {$urandom, $urandom});
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    drain();

    // start count at all ones keeps a new target in pass-through
    reg_write(REG_START_COUNT, 64'hFFFF_FFFF);
    reg_write(REG_MAX_GAIN, 64'd200);
    send_sample(16'sh1234);
    send_sample(-16'sh1);

    phase_cnt = 0;
    while (samples_sent < ITEMS) begin
      drain();
      if (samples_sent > ITEMS - 120) idle_en = 1'b0;
      if ($urandom_range(0, 3) != 0)
        reg_write(REG_START_COUNT, 64'(samples_sent + $urandom_range(0, 6)));
      case ($urandom_range(0, 9))
        0:       mg = '0;
        1:       mg = '1;
        default: mg = 16'($urandom_range(1, 8000));
      endcase
      reg_write(REG_MAX_GAIN, {48'd0, mg});
      case ($urandom_range(0, 9))
        0:       step = '0;
        1:       step = STEP_MAX;
        default: begin
          step = ({48'd0, mg} << (GAIN_FRAC_BITS_DEF - MAX_GAIN_FRAC))
                 / 64'($urandom_range(1, 25));
          if (step > STEP_MAX) step = STEP_MAX;
        end
      endcase
      reg_write(REG_GAIN_STEP, step);
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0:       reg_write(REG_MAX_DELAY, 64'd0);
          1:       reg_write(REG_MAX_DELAY, 64'hFFFF);
          default: reg_write(REG_MAX_DELAY, 64'($urandom_range(1, 40)));
        endcase
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0:       reg_write(REG_DELAY_STEP, 64'd0);
          1:       reg_write(REG_DELAY_STEP, 64'hFF_FFFF);
          default: reg_write(REG_DELAY_STEP, 64'($urandom_range(1 << 22, (1 << 24) - 1)));
        endcase
      end
      if (phase_cnt == 2) hold_req = 1'b1;
      n = $urandom_range(15, 45);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0:       sample = 16'sh7FFF;
            1:       sample = -16'sh8000;
            2:       sample = '1;
            default: sample = '0;
          endcase
        end else begin
          sample = 16'($urandom);
        end
        send_sample(sample);
      end
      phase_cnt++;
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d samples over %0d random settings, %0d register writes,",
             samples_sent, phase_cnt, cfg_writes);
    $display("%0d result words compared; phases seen %b, events seen %b",
             checked, phases_seen, events_seen);
    if (fail_cnt == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== gain_ramp_growing_delay_mixer.f =====
sv/grgdm_pkg.sv
sv/grgdm_in_if.sv
sv/grgdm_out_if.sv
sv/grgdm_mix.sv
sv/gain_ramp_growing_delay_mixer.sv
tb/grgdm_mix_check.sv
tb/gain_ramp_growing_delay_mixer_tb.sv
